/* hw/rtl/ismq_pkg.sv */
`timescale 1ns / 1ps

package ismq_pkg;

   // Table and tag dimensions.
   localparam int DEF_MAX_ENTRIES = 256;
   localparam int DEF_NUM_SEQS    = 16;
   localparam int POS_W           = 31;
   localparam int TAG_W           = 4;

   // Command codes.
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_ADD   = 2'd1,
      CMD_QUERY = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   // Status codes.
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One table entry.
   typedef struct packed {
      logic [TAG_W-1:0] tag;
      logic [POS_W-1:0] s;
      logic [POS_W-1:0] e;
   } entry_type;

endpackage

/* hw/rtl/interval_set_merge_and_point_query_unit.sv */
`timescale 1ns / 1ps
// Clear, unused and rejected commands strobe the result in the cycle after acceptance.
// A query is a binary search with one memory read per search step.
// An add does a linear scan, then shifts the table entry by entry through the memory.
// busy stays high through the result cycle, so a new command is taken only after the result;
// the receiver cannot stall and takes each result in its strobe cycle.
// Reset clears the entry count and the controller; the table memory is not cleared.
module interval_set_merge_and_point_query_unit #(
   parameter int MAX_ENTRIES = ismq_pkg::DEF_MAX_ENTRIES,
   parameter int NUM_SEQS    = ismq_pkg::DEF_NUM_SEQS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_cmd,
   input  logic [ismq_pkg::TAG_W-1:0]  req_seq_id,
   input  logic [ismq_pkg::POS_W-1:0]  req_start_pos,
   input  logic [ismq_pkg::POS_W-1:0]  req_end_pos,
   input  logic [ismq_pkg::POS_W-1:0]  req_query_pos,
   output logic                        rsp_valid,
   output logic                        rsp_hit,
   output logic [1:0]                  rsp_status,
   output logic [$clog2(MAX_ENTRIES+1)-1:0] rsp_entries_used
);
   import ismq_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_QRD   = 10'b0000000010,
      S_QCMP  = 10'b0000000100,
      S_SCRD  = 10'b0000001000,
      S_SCCMP = 10'b0000010000,
      S_MGRD  = 10'b0000100000,
      S_MGCMP = 10'b0001000000,
      S_SHIFT = 10'b0010000000,
      S_CPRD  = 10'b0100000000,
      S_DONE  = 10'b1000000000
   } state_type;

   // Table memory, one read and one write per cycle, usable together.
   entry_type mem [MAX_ENTRIES];
   entry_type rd_ff;
   logic          mem_we;
   logic [AW-1:0] mem_wa;
   logic [AW-1:0] mem_ra;
   entry_type     mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, j_ff, j_in, k_ff, k_in;
   logic [TAG_W-1:0] tag_ff, tag_in;
   logic [POS_W-1:0] s_ff, s_in, e_ff, e_in, q_ff, q_in;
   logic hit_ff, hit_in;
   logic [1:0] st_ff, st_in;
   logic [CW-1:0] mid;
   logic tag_ok;

   assign mid    = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign tag_ok = ({{(9-TAG_W){1'b0}}, req_seq_id} < 9'(NUM_SEQS));
   assign busy   = (state_ff != S_IDLE);

   // Control and datapath sequencing.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in = lo_ff; hi_in = hi_ff; j_in = j_ff; k_in = k_ff;
      tag_in = tag_ff; s_in = s_ff; e_in = e_ff; q_in = q_ff;
      hit_in = hit_ff; st_in = st_ff;
      mem_we = 1'b0;
      mem_wa = lo_ff[AW-1:0];
      mem_wd = '{tag: tag_ff, s: s_ff, e: e_ff};
      mem_ra = mid[AW-1:0];
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               tag_in = req_seq_id; s_in = req_start_pos;
               e_in = req_end_pos; q_in = req_query_pos;
               hit_in = 1'b0; st_in = ST_OK;
               lo_in = '0; hi_in = count_ff; j_in = '0;
               state_in = S_DONE;
               unique case (cmd_type'(req_cmd))
                  CMD_CLEAR: count_in = '0;
                  CMD_ADD: begin
                     if (req_end_pos <= req_start_pos || !tag_ok) st_in = ST_EMPTY;
                     else state_in = S_SCRD;
                  end
                  CMD_QUERY: if (tag_ok) state_in = S_QRD;
                  CMD_NONE: ;
                  default: ;
               endcase
            end
         end
         // Binary search: issue read of the middle entry.
         S_QRD: begin
            if (lo_ff < hi_ff) state_in = S_QCMP;
            else state_in = S_DONE;
         end
         S_QCMP: begin
            if (tag_ff < rd_ff.tag || (tag_ff == rd_ff.tag && q_ff < rd_ff.s))
               hi_in = mid;
            else if (tag_ff > rd_ff.tag || q_ff >= rd_ff.e)
               lo_in = mid + 1'b1;
            else begin
               hit_in = 1'b1;
               state_in = S_DONE;
            end
            if (state_in != S_DONE) state_in = S_QRD;
         end
         // Scan for first entry that may merge.
         S_SCRD: begin
            mem_ra = lo_ff[AW-1:0];
            if (lo_ff < count_ff) state_in = S_SCCMP;
            else begin
               j_in = lo_ff;
               state_in = S_MGRD;
            end
         end
         S_SCCMP: begin
            if (rd_ff.tag < tag_ff || (rd_ff.tag == tag_ff && rd_ff.e < s_ff)) begin
               lo_in = lo_ff + 1'b1;
               state_in = S_SCRD;
            end else begin
               j_in = lo_ff;
               state_in = S_MGRD;
            end
         end
         // Absorb overlapping entries.
         S_MGRD: begin
            mem_ra = j_ff[AW-1:0];
            if (j_ff < count_ff) state_in = S_MGCMP;
            else state_in = S_SHIFT;
         end
         S_MGCMP: begin
            if (rd_ff.tag == tag_ff && rd_ff.s <= e_ff) begin
               if (rd_ff.s < s_ff) s_in = rd_ff.s;
               if (rd_ff.e > e_ff) e_in = rd_ff.e;
               j_in = j_ff + 1'b1;
               state_in = S_MGRD;
            end else state_in = S_SHIFT;
         end
         // Pick the move direction; k walks the copy.
         S_SHIFT: begin
            if (j_ff == lo_ff) begin
               if (count_ff >= CW'(MAX_ENTRIES)) begin
                  st_in = ST_FULL;
                  state_in = S_DONE;
               end else begin
                  k_in = count_ff;
                  state_in = S_CPRD;
               end
            end else begin
               k_in = j_ff;
               state_in = S_CPRD;
            end
         end
         // Copy one entry: read then write next cycle.
         S_CPRD: begin
            if (j_ff == lo_ff) begin
               // Insert: move entries up, from the top down.
               mem_ra = k_ff[AW-1:0] - 1'b1;
               if (k_ff == lo_ff) begin
                  mem_we = 1'b1;
                  count_in = count_ff + 1'b1;
                  state_in = S_DONE;
               end else if (hit_ff) begin
                  mem_we = 1'b1; mem_wa = k_ff[AW-1:0]; mem_wd = rd_ff;
                  k_in = k_ff - 1'b1; hit_in = 1'b0;
               end else hit_in = 1'b1;
            end else begin
               // Merge: write merged entry, then move the tail down.
               mem_ra = k_ff[AW-1:0];
               if (!hit_ff && k_ff == j_ff) begin
                  mem_we = 1'b1;
                  if (k_ff < count_ff) hit_in = 1'b1;
                  else begin
                     count_in = count_ff - (j_ff - lo_ff) + 1'b1;
                     state_in = S_DONE;
                  end
               end else begin
                  // The read for the next tail entry goes out while this one is written.
                  mem_ra = AW'(k_ff + 1'b1);
                  mem_we = 1'b1;
                  mem_wa = AW'(lo_ff + 1'b1 + (k_ff - j_ff));
                  mem_wd = rd_ff;
                  k_in = k_ff + 1'b1;
                  if (k_ff + 1'b1 >= count_ff) begin
                     count_in = count_ff - (j_ff - lo_ff) + 1'b1;
                     hit_in = 1'b0;
                     state_in = S_DONE;
                  end
               end
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // In the merge copy, the first data write happens in the cycle after the read.
   // hit_ff is reused as a "read outstanding" flag during copies and cleared after.

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         hit_ff   <= hit_in;
      end
      lo_ff <= lo_in; hi_ff <= hi_in; j_ff <= j_in; k_ff <= k_in;
      tag_ff <= tag_in; s_ff <= s_in; e_ff <= e_in; q_ff <= q_in;
      st_ff <= st_in;
   end

   assign rsp_valid        = (state_ff == S_DONE);
   assign rsp_hit          = hit_ff;
   assign rsp_status       = st_ff;
   assign rsp_entries_used = count_ff;

`ifndef SYNTHESIS
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ENTRIES)) else $error("entry count over capacity");
   a_busy_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a command");
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("repeated result");
   a_full_keeps: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |-> count_ff == CW'(MAX_ENTRIES))
      else $error("full status with room left");
`endif

endmodule
